FILE: design/drcl_pkg.sv
// Package: shared types, codes and constants of the run-list cluster lookup.
`default_nettype none

package drcl_pkg;

   // Default width of cluster arithmetic; every cluster sum wraps at this width.
   localparam int CLUSTER_BITS_DEF = 64;

   // Fixed widths of the word fields.
   localparam int BYTE_W   = 8;
   localparam int VCN_W    = 64;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 5;
   localparam int NIBBLE_W = 4;

   // Mask of one header nibble.
   localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hf;

   // Number of bytes of a count or offset field that are kept.
   localparam logic [INDEX_W-1:0] KEPT_BYTES = 5'd8;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FOUND = 2'd0,
      ST_RANGE = 2'd1,
      ST_END   = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] run_byte;
      logic              list_start;
      logic [VCN_W-1:0]  target_vcn;
      logic [VCN_W-1:0]  low_vcn;
      logic [VCN_W-1:0]  high_vcn;
   } req_word_type;

   typedef struct packed {
      logic              emit;
      status_type        status;
      logic [VCN_W-1:0]  lcn_out;
      logic [VCN_W-1:0]  run_remaining;
   } result_type;

endpackage

`default_nettype wire

FILE: design/drcl_if.sv
// Interfaces: request and response channels of the run-list cluster lookup.
`default_nettype none

interface drcl_req_if
   import drcl_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] run_byte;
   logic              list_start;
   logic [VCN_W-1:0]  target_vcn;
   logic [VCN_W-1:0]  low_vcn;
   logic [VCN_W-1:0]  high_vcn;

   modport source (output valid, run_byte, list_start, target_vcn, low_vcn, high_vcn,
                   input ready);
   modport sink   (input valid, run_byte, list_start, target_vcn, low_vcn, high_vcn,
                   output ready);
endinterface

interface drcl_rsp_if
   import drcl_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VCN_W-1:0]    lcn_out;
   logic [VCN_W-1:0]    run_remaining;

   modport source (output valid, status, lcn_out, run_remaining, input ready);
   modport sink   (input valid, status, lcn_out, run_remaining, output ready);
endinterface

`default_nettype wire

FILE: design/drcl_in_reg.sv
// Input register: holds one request word until the walker consumes it.
`default_nettype none

module drcl_in_reg
   import drcl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   drcl_req_if.sink          req_ch,
   input  wire logic         advance,
   output      logic         item_valid,
   output      req_word_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         take;

   assign req_ch.ready = !valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register needs no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff.run_byte   <= req_ch.run_byte;
         word_ff.list_start <= req_ch.list_start;
         word_ff.target_vcn <= req_ch.target_vcn;
         word_ff.low_vcn    <= req_ch.low_vcn;
         word_ff.high_vcn   <= req_ch.high_vcn;
      end
   end

   assign item_valid = valid_ff;
   assign item       = word_ff;

endmodule

`default_nettype wire

FILE: design/drcl_walker.sv
// Run-list walker: parse state, field assembly, run match and result build.
`default_nettype none

module drcl_walker
   import drcl_pkg::*;
#(
   parameter int CLUSTER_BITS = CLUSTER_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_word_type item,
   output      result_type   result
);

   localparam int ClW = CLUSTER_BITS;

   phase_type            phase_ff, phase_in;
   logic [NIBBLE_W-1:0]  cw_ff, cw_in;
   logic [NIBBLE_W-1:0]  ow_ff, ow_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [ClW-1:0]       cnt_acc_ff, cnt_acc_in;
   logic [ClW-1:0]       off_acc_ff, off_acc_in;
   logic [ClW-1:0]       run_lcn_ff, run_lcn_in;
   logic [ClW-1:0]       run_base_ff, run_base_in;
   logic [ClW-1:0]       query_ff, query_in;

   // Decoded view of the current word.
   logic [BYTE_W-1:0]    b;
   logic [ClW-1:0]       q_new, lo_new, hi_new;
   logic                 out_of_range;
   logic                 hdr_sel, body_sel, hdr_zero;
   logic                 is_cnt, cnt_hit, off_hit, sign_hit, last;
   logic [INDEX_W-1:0]   oi;
   logic [2:0]           pos;
   logic [VCN_W-1:0]     placed64, fill64;
   logic [ClW-1:0]       cnt_new, off_new, run_end, lcn_sum, delta, lcn_val;
   logic                 match;

   assign b            = item.run_byte;
   assign q_new        = item.target_vcn[ClW-1:0];
   assign lo_new       = item.low_vcn[ClW-1:0];
   assign hi_new       = item.high_vcn[ClW-1:0];
   assign out_of_range = (q_new < lo_new) || (q_new > hi_new);
   assign hdr_sel      = item.list_start ? !out_of_range : (phase_ff == PH_HEADER);
   assign body_sel     = !item.list_start && (phase_ff == PH_BODY);
   assign hdr_zero     = (b == '0);

   // Field bytes: count bytes first, then offset bytes; bytes past the eighth drop.
   assign is_cnt   = idx_ff < {1'b0, cw_ff};
   assign oi       = idx_ff - {1'b0, cw_ff};
   assign pos      = is_cnt ? idx_ff[2:0] : oi[2:0];
   assign placed64 = VCN_W'(b) << {pos, 3'b000};
   assign fill64   = ~VCN_W'(0) << {ow_ff[2:0], 3'b000};
   assign cnt_hit  = is_cnt && (idx_ff < KEPT_BYTES);
   assign off_hit  = !is_cnt && (oi < KEPT_BYTES);
   assign sign_hit = !is_cnt && ((oi + 5'd1) == {1'b0, ow_ff})
                     && (ow_ff < 4'd8) && b[BYTE_W-1];
   assign last     = ({1'b0, idx_ff} + 6'd1) >= ({2'b00, cw_ff} + {2'b00, ow_ff});

   always_comb begin
      cnt_new = cnt_acc_ff;
      off_new = off_acc_ff;
      if (cnt_hit) begin
         cnt_new = cnt_acc_ff | placed64[ClW-1:0];
      end
      if (off_hit) begin
         off_new = off_new | placed64[ClW-1:0];
      end
      if (sign_hit) begin
         off_new = off_new | fill64[ClW-1:0];
      end
   end

   // Run end, match test and mapped cluster of the target.
   assign run_end = run_base_ff + cnt_new;
   assign match   = (run_base_ff <= query_ff) && (query_ff < run_end);
   assign delta   = query_ff - run_base_ff;
   assign lcn_sum = run_lcn_ff + off_new;
   assign lcn_val = (off_new == '0) ? '0 : (lcn_sum + delta);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (item.list_start && out_of_range) begin
            phase_in = PH_IDLE;
         end else if (hdr_sel) begin
            phase_in = hdr_zero ? PH_IDLE : PH_BODY;
         end else if (body_sel && last) begin
            phase_in = match ? PH_IDLE : PH_HEADER;
         end
      end
   end

   // Datapath registers and result.
   always_comb begin
      cw_in       = cw_ff;
      ow_in       = ow_ff;
      idx_in      = idx_ff;
      cnt_acc_in  = cnt_acc_ff;
      off_acc_in  = off_acc_ff;
      run_lcn_in  = run_lcn_ff;
      run_base_in = run_base_ff;
      query_in    = query_ff;
      result      = '{emit: 1'b0, status: ST_FOUND, lcn_out: '0, run_remaining: '0};
      if (step) begin
         if (item.list_start) begin
            query_in = q_new;
            if (out_of_range) begin
               result.emit   = 1'b1;
               result.status = ST_RANGE;
            end else begin
               run_base_in = lo_new;
               run_lcn_in  = '0;
            end
         end
         if (hdr_sel) begin
            if (hdr_zero) begin
               result.emit   = 1'b1;
               result.status = ST_END;
            end else begin
               cw_in      = b[NIBBLE_W-1:0] & NIBBLE_MASK;
               ow_in      = b[BYTE_W-1:NIBBLE_W] & NIBBLE_MASK;
               idx_in     = '0;
               cnt_acc_in = '0;
               off_acc_in = '0;
            end
         end else if (body_sel) begin
            cnt_acc_in = cnt_new;
            off_acc_in = off_new;
            idx_in     = idx_ff + 5'd1;
            if (last) begin
               run_lcn_in = lcn_sum;
               if (match) begin
                  result.emit          = 1'b1;
                  result.status        = ST_FOUND;
                  result.lcn_out       = VCN_W'(lcn_val);
                  result.run_remaining = VCN_W'(cnt_new - delta);
               end else begin
                  run_base_in = run_end;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Every field below is loaded before it is read, so it carries no reset.
   always_ff @(posedge clock) begin
      cw_ff       <= cw_in;
      ow_ff       <= ow_in;
      idx_ff      <= idx_in;
      cnt_acc_ff  <= cnt_acc_in;
      off_acc_ff  <= off_acc_in;
      run_lcn_ff  <= run_lcn_in;
      run_base_ff <= run_base_in;
      query_ff    <= query_in;
   end

endmodule

`default_nettype wire

FILE: design/drcl_out_reg.sv
// Output register: holds one response word until the receiver takes it.
`default_nettype none

module drcl_out_reg
   import drcl_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   output      logic       slot_free,
   drcl_rsp_if.source      rsp_ch
);

   logic       valid_ff, valid_in;
   result_type word_ff;

   assign slot_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (result.emit) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.emit) begin
         word_ff <= result;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.status        = word_ff.status;
   assign rsp_ch.lcn_out       = word_ff.lcn_out;
   assign rsp_ch.run_remaining = word_ff.run_remaining;

endmodule

`default_nettype wire

FILE: design/data_run_cluster_lookup_top.sv
// Top level: run-list cluster lookup with input register, walker and output register.
//
// The block walks an extent run list one byte per request word and reports where a
// target virtual cluster lives. The word with list_start high opens a list and also
// carries target_vcn, low_vcn and high_vcn; a list start in any state drops the list
// being walked. Each later word brings the next run-list byte.
// A response word is sent once per list: status found with the logical cluster and
// the clusters left in the run, status range when the target is outside
// low_vcn..high_vcn, or status end when a zero header closes the list. Bytes after
// the response are ignored until the next list start.
// Throughput is one request word per cycle while the receiver takes responses.
// The walker updates its parse state for a byte between the input and output registers.
// A word accepted into the input register is parsed once the output register has room,
// and its response is registered in the output register and then driven on rsp_ch.
// When the receiver stalls, the output register holds the response and the input
// register keeps the next word, so the request side stalls only while both are full.
// Synchronous reset empties both registers and returns the walker to idle.
`default_nettype none

module data_run_cluster_lookup_top
   import drcl_pkg::*;
#(
   parameter int CLUSTER_BITS = CLUSTER_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   drcl_req_if.sink   req_ch,
   drcl_rsp_if.source rsp_ch
);

   logic         item_valid;
   req_word_type item;
   logic         slot_free;
   logic         advance;
   result_type   result;

   // A word is parsed only when the output register can take whatever it produces.
   assign advance = item_valid && slot_free;

   drcl_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   drcl_walker #(
      .CLUSTER_BITS (CLUSTER_BITS)
   ) u_walker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   drcl_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

FILE: design/drcl_checker.sv
// Checker: port-level properties of the run-list cluster lookup, bound to the top level.
`default_nettype none

module drcl_checker
   import drcl_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [VCN_W-1:0]    rsp_lcn_out,
   input wire logic [VCN_W-1:0]    rsp_run_remaining
);

   // A stalled response keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_lcn_out) && $stable(rsp_run_remaining))
      else $error("response word changed while stalled");

   // Only the three defined status codes are ever sent.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_FOUND) || (rsp_status == ST_RANGE)
         || (rsp_status == ST_END))
      else $error("undefined status code");

   // A miss carries no cluster and no run length.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_FOUND) |-> (rsp_lcn_out == '0)
         && (rsp_run_remaining == '0))
      else $error("miss response with nonzero cluster fields");

   // A found target always has at least one cluster left in its run.
   a_found_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FOUND) |-> (rsp_run_remaining != '0))
      else $error("found response with empty run");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind data_run_cluster_lookup_top drcl_checker u_drcl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_status        (rsp_ch.status),
   .rsp_lcn_out       (rsp_ch.lcn_out),
   .rsp_run_remaining (rsp_ch.run_remaining)
);

`default_nettype wire
